### rtl/ardf_pkg.sv
package ardf_pkg;

  localparam int unsigned HEADER_BYTES_DEF = 16;

  localparam logic [15:0] MAGIC_LEN   = 16'd4;
  localparam logic [15:0] VERSION_POS = 16'd4;
  localparam logic [15:0] CODEC_POS   = 16'd5;
  localparam logic [15:0] FIELDS_LO   = 16'd6;
  localparam logic [15:0] FIELDS_HI   = 16'd11;
  localparam logic [15:0] RSVD_LO     = 16'd12;
  localparam logic [15:0] RSVD_HI     = 16'd15;
  localparam logic [16:0] TRAILER_LEN = 17'd6;

  // x / 1000 == (x * FS_RECIP) >> FS_SHIFT for every x below 2^24
  localparam logic [24:0] FS_RECIP = 25'd17179870;
  localparam int unsigned FS_SHIFT = 34;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_TRAILER = 3'd3,
    PH_ENDED   = 3'd4,
    PH_FAILED  = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    EV_NEED_MORE   = 4'd0,
    EV_HEADER      = 4'd1,
    EV_PACKET      = 4'd2,
    EV_TRAILER     = 4'd3,
    EV_BAD_MAGIC   = 4'd4,
    EV_BAD_FORMAT  = 4'd5,
    EV_BAD_LENGTH  = 4'd6,
    EV_BAD_TRAILER = 4'd7,
    EV_AFTER_END   = 4'd8
  } event_e;

  typedef enum logic [2:0] {
    CFG_MAGIC     = 3'd0,
    CFG_VERSION   = 3'd1,
    CFG_CODEC     = 3'd2,
    CFG_TRAILER   = 3'd3,
    CFG_PKT_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [7:0]  format_version;
    logic [7:0]  codec_id;
    logic [15:0] trailer_code;
    logic [15:0] packet_limit;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [15:0] sample_rate;
    logic [7:0]  channel_count;
    logic [7:0]  frame_millis;
    logic [15:0] pre_skip_samples;
    logic [31:0] end_sample_count;
    logic [31:0] packets_seen;
    logic [31:0] bytes_taken;
  } res_t;

endpackage

### rtl/ardf_parser.sv
module ardf_parser import ardf_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       en_i,
  input  logic [7:0] data_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic        magic_ok_q, magic_ok_d;
  logic        fmt_ok_q, fmt_ok_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] rec_len_q, rec_len_d;
  logic [47:0] hdr_q, hdr_d;
  logic [47:0] trl_q, trl_d;
  logic [31:0] pkt_cnt_q, pkt_cnt_d;
  logic [31:0] byte_cnt_q, byte_cnt_d;

  logic [16:0] idx_inc;
  logic [15:0] rec_len_in;
  logic [2:0]  hdr_pos;
  logic [2:0]  trl_pos;
  logic [15:0] hdr_off;
  event_e      ev;
  logic        pv;
  logic        pl;
  res_t        res_d, res_q;

  assign idx_inc    = {1'b0, idx_q} + 17'd1;
  assign rec_len_in = {data_byte_i, len_lo_q};
  assign hdr_off    = idx_q - FIELDS_LO;
  assign hdr_pos    = hdr_off[2:0];
  assign trl_pos    = idx_q[2:0];

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    magic_ok_d = magic_ok_q;
    fmt_ok_d   = fmt_ok_q;
    len_lo_d   = len_lo_q;
    rec_len_d  = rec_len_q;
    hdr_d      = hdr_q;
    trl_d      = trl_q;
    pkt_cnt_d  = pkt_cnt_q;
    byte_cnt_d = byte_cnt_q;
    ev         = EV_NEED_MORE;
    pv         = 1'b0;
    pl         = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        byte_cnt_d = byte_cnt_q + 32'd1;
        if (idx_q < MAGIC_LEN) begin
          if (data_byte_i != cfg_i.magic_word[{idx_q[1:0], 3'b000} +: 8]) begin
            magic_ok_d = 1'b0;
          end
        end else if (idx_q == VERSION_POS) begin
          if (data_byte_i != cfg_i.format_version) fmt_ok_d = 1'b0;
        end else if (idx_q == CODEC_POS) begin
          if (data_byte_i != cfg_i.codec_id) fmt_ok_d = 1'b0;
        end else if (idx_q >= FIELDS_LO && idx_q <= FIELDS_HI) begin
          hdr_d[{hdr_pos, 3'b000} +: 8] = data_byte_i;
        end else if (idx_q >= RSVD_LO && idx_q <= RSVD_HI) begin
          if (data_byte_i != 8'd0) fmt_ok_d = 1'b0;
        end
        if (idx_inc >= 17'(HEADER_BYTES)) begin
          idx_d = 16'd0;
          if (!magic_ok_d) begin
            ev      = EV_BAD_MAGIC;
            phase_d = PH_FAILED;
          end else if (!fmt_ok_d) begin
            ev      = EV_BAD_FORMAT;
            phase_d = PH_FAILED;
          end else begin
            ev      = EV_HEADER;
            phase_d = PH_LENGTH;
          end
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      PH_LENGTH: begin
        byte_cnt_d = byte_cnt_q + 32'd1;
        if (idx_q == 16'd0) begin
          len_lo_d = data_byte_i;
          idx_d    = 16'd1;
        end else begin
          idx_d = 16'd0;
          if (rec_len_in == 16'd0) begin
            phase_d = PH_TRAILER;
          end else if (rec_len_in > cfg_i.packet_limit) begin
            ev      = EV_BAD_LENGTH;
            phase_d = PH_FAILED;
          end else begin
            rec_len_d = rec_len_in;
            phase_d   = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        byte_cnt_d = byte_cnt_q + 32'd1;
        pv         = 1'b1;
        if (idx_inc >= {1'b0, rec_len_q}) begin
          pl        = 1'b1;
          ev        = EV_PACKET;
          pkt_cnt_d = pkt_cnt_q + 32'd1;
          idx_d     = 16'd0;
          phase_d   = PH_LENGTH;
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      PH_TRAILER: begin
        byte_cnt_d = byte_cnt_q + 32'd1;
        trl_d[{trl_pos, 3'b000} +: 8] = data_byte_i;
        if (idx_inc >= TRAILER_LEN) begin
          idx_d = 16'd0;
          if (trl_d[15:0] != cfg_i.trailer_code) begin
            ev      = EV_BAD_TRAILER;
            phase_d = PH_FAILED;
          end else begin
            ev      = EV_TRAILER;
            phase_d = PH_ENDED;
          end
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      PH_ENDED: begin
        ev      = EV_AFTER_END;
        phase_d = PH_FAILED;
      end
      default: begin
        ev      = EV_BAD_FORMAT;
        phase_d = PH_FAILED;
      end
    endcase
  end

  always_comb begin
    res_d.event_res        = ev;
    res_d.payload_valid    = pv;
    res_d.payload_byte     = pv ? data_byte_i : 8'd0;
    res_d.payload_last     = pl;
    res_d.sample_rate      = hdr_d[15:0];
    res_d.channel_count    = hdr_d[23:16];
    res_d.frame_millis     = hdr_d[31:24];
    res_d.pre_skip_samples = hdr_d[47:32];
    res_d.end_sample_count = trl_d[47:16];
    res_d.packets_seen     = pkt_cnt_d;
    res_d.bytes_taken      = byte_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      idx_q      <= 16'd0;
      magic_ok_q <= 1'b1;
      fmt_ok_q   <= 1'b1;
      len_lo_q   <= 8'd0;
      rec_len_q  <= 16'd0;
      hdr_q      <= 48'd0;
      trl_q      <= 48'd0;
      pkt_cnt_q  <= 32'd0;
      byte_cnt_q <= 32'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      magic_ok_q <= magic_ok_d;
      fmt_ok_q   <= fmt_ok_d;
      len_lo_q   <= len_lo_d;
      rec_len_q  <= rec_len_d;
      hdr_q      <= hdr_d;
      trl_q      <= trl_d;
      pkt_cnt_q  <= pkt_cnt_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/ardf_frame_math.sv
module ardf_frame_math import ardf_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] sample_rate_i,
  input  logic [7:0]  frame_millis_i,
  output logic [14:0] frame_samples_o
);

  logic [23:0] prod_q, prod_d;
  logic [48:0] scaled;
  logic [14:0] quot_q, quot_d;

  assign prod_d = 24'(sample_rate_i) * 24'(frame_millis_i);

  // divide by 1000 through the reciprocal
  assign scaled = 49'(prod_q) * 49'(FS_RECIP);
  assign quot_d = scaled[FS_SHIFT +: 15];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      quot_q <= quot_d;
    end
  end

  assign frame_samples_o = quot_q;

endmodule

### rtl/audio_record_stream_deframer.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   data_byte_i
// out       output     out_valid_o / out_ready_i event_res_o .. bytes_taken_o
// cfg       input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// One byte per clock while results are taken; each result is registered through
// the parse stage, rate x frame multiply and reciprocal multiply (divide by 1000).
// Reset clears the parse state and counters and loads the register defaults.
// While the output holds an untaken result the whole pipeline holds and
// in_ready_o drops; it follows out_ready_i within the same cycle.
module audio_record_stream_deframer import ardf_pkg::*; #(
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  event_res_o,
  output logic        payload_valid_o,
  output logic [7:0]  payload_byte_o,
  output logic        payload_last_o,
  output logic [15:0] sample_rate_o,
  output logic [7:0]  channel_count_o,
  output logic [7:0]  frame_millis_o,
  output logic [15:0] pre_skip_samples_o,
  output logic [14:0] frame_samples_o,
  output logic [31:0] end_sample_count_o,
  output logic [31:0] packets_seen_o,
  output logic [31:0] bytes_taken_o
);

  cfg_t cfg_q, cfg_d;
  logic en;
  logic fire;
  logic v1_q, v2_q, v3_q;
  res_t r1, r2_q, r3_q;
  logic [14:0] frame_samples;

  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;
  assign fire       = in_valid_i && en;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_MAGIC:     cfg_d.magic_word     = cfg_wdata_i;
        CFG_VERSION:   cfg_d.format_version = cfg_wdata_i[7:0];
        CFG_CODEC:     cfg_d.codec_id       = cfg_wdata_i[7:0];
        CFG_TRAILER:   cfg_d.trailer_code   = cfg_wdata_i[15:0];
        CFG_PKT_LIMIT: cfg_d.packet_limit   = cfg_wdata_i[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word     <= 32'd0;
      cfg_q.format_version <= 8'd1;
      cfg_q.codec_id       <= 8'd0;
      cfg_q.trailer_code   <= 16'd0;
      cfg_q.packet_limit   <= 16'd1275;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  ardf_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .en_i        (en),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg_q),
    .res_o       (r1)
  );

  ardf_frame_math u_frame_math (
    .clk_i           (clk_i),
    .en_i            (en),
    .sample_rate_i   (r1.sample_rate),
    .frame_millis_i  (r1.frame_millis),
    .frame_samples_o (frame_samples)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q <= r1;
      r3_q <= r2_q;
    end
  end

  assign out_valid_o        = v3_q;
  assign event_res_o        = r3_q.event_res;
  assign payload_valid_o    = r3_q.payload_valid;
  assign payload_byte_o     = r3_q.payload_byte;
  assign payload_last_o     = r3_q.payload_last;
  assign sample_rate_o      = r3_q.sample_rate;
  assign channel_count_o    = r3_q.channel_count;
  assign frame_millis_o     = r3_q.frame_millis;
  assign pre_skip_samples_o = r3_q.pre_skip_samples;
  assign frame_samples_o    = frame_samples;
  assign end_sample_count_o = r3_q.end_sample_count;
  assign packets_seen_o     = r3_q.packets_seen;
  assign bytes_taken_o      = r3_q.bytes_taken;

endmodule

### bench/record_stream_checker.sv
`timescale 1ns / 100ps

module record_stream_checker import ardf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        data_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [3:0]        event_res_i,
  input  logic              payload_valid_i,
  input  logic [7:0]        payload_byte_i,
  input  logic              payload_last_i,
  input  logic [15:0]       sample_rate_i,
  input  logic [7:0]        channel_count_i,
  input  logic [7:0]        frame_millis_i,
  input  logic [15:0]       pre_skip_samples_i,
  input  logic [14:0]       frame_samples_i,
  input  logic [31:0]       end_sample_count_i,
  input  logic [31:0]       packets_seen_i,
  input  logic [31:0]       bytes_taken_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  localparam int unsigned HDR_LEN  = HEADER_BYTES_DEF;
  localparam int unsigned TRL_LEN  = 6;
  localparam int unsigned MS_PER_S = 1000;

  typedef struct packed {
    event_e      ev;
    logic        pv;
    logic [7:0]  pb;
    logic        pl;
    logic [15:0] rate;
    logic [7:0]  chans;
    logic [7:0]  frm_millis;
    logic [15:0] skip_samples;
    logic [14:0] frame_smp;
    logic [31:0] end_count;
    logic [31:0] packets;
    logic [31:0] bytes;
  } deframe_result_t;

  // register copies
  logic [31:0] magic_cfg;
  logic [7:0]  version_cfg;
  logic [7:0]  codec_cfg;
  logic [15:0] trailer_cfg;
  logic [15:0] limit_cfg;

  // parser state
  phase_e      phase;
  logic [15:0] field_idx;
  logic        magic_ok;
  logic        format_ok;
  logic [7:0]  len_low;
  logic [15:0] rec_len;
  logic [47:0] hdr_fields;
  logic [47:0] trl_fields;
  logic [31:0] packet_cnt;
  logic [31:0] byte_cnt;

  deframe_result_t expected_events[$];

  task automatic parse_stream_byte(input logic [7:0] b, output deframe_result_t r);
    logic [15:0] idx;
    logic [15:0] len;
    logic [31:0] prod;
    idx = field_idx;
    r = '0;
    r.ev = EV_NEED_MORE;
    case (phase)
      PH_HEADER: begin
        byte_cnt++;
        if (idx < 4) begin
          if (b != magic_cfg[8*idx +: 8]) magic_ok = 1'b0;
        end else if (idx == 4) begin
          if (b != version_cfg) format_ok = 1'b0;
        end else if (idx == 5) begin
          if (b != codec_cfg) format_ok = 1'b0;
        end else if (idx >= 6 && idx <= 11) begin
          hdr_fields[8*(idx-6) +: 8] = b;
        end else if (idx >= 12 && idx <= 15) begin
          if (b != 8'd0) format_ok = 1'b0;
        end
        if (idx + 32'd1 >= HDR_LEN) begin
          field_idx = '0;
          // magic is checked ahead of version, codec and reserved word
          if (!magic_ok) begin
            r.ev = EV_BAD_MAGIC;
            phase = PH_FAILED;
          end else if (!format_ok) begin
            r.ev = EV_BAD_FORMAT;
            phase = PH_FAILED;
          end else begin
            r.ev = EV_HEADER;
            phase = PH_LENGTH;
          end
        end else begin
          field_idx = idx + 16'd1;
        end
      end
      PH_LENGTH: begin
        byte_cnt++;
        if (idx == 0) begin
          len_low = b;
          field_idx = 16'd1;
        end else begin
          len = {b, len_low};
          field_idx = '0;
          if (len == 16'd0) begin
            phase = PH_TRAILER;
          end else if (len > limit_cfg) begin
            r.ev = EV_BAD_LENGTH;
            phase = PH_FAILED;
          end else begin
            rec_len = len;
            phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        byte_cnt++;
        r.pv = 1'b1;
        r.pb = b;
        if (idx + 32'd1 >= rec_len) begin
          r.pl = 1'b1;
          r.ev = EV_PACKET;
          packet_cnt++;
          field_idx = '0;
          phase = PH_LENGTH;
        end else begin
          field_idx = idx + 16'd1;
        end
      end
      PH_TRAILER: begin
        byte_cnt++;
        trl_fields[8*idx +: 8] = b;
        if (idx + 32'd1 >= TRL_LEN) begin
          field_idx = '0;
          if (trl_fields[15:0] != trailer_cfg) begin
            r.ev = EV_BAD_TRAILER;
            phase = PH_FAILED;
          end else begin
            r.ev = EV_TRAILER;
            phase = PH_ENDED;
          end
        end else begin
          field_idx = idx + 16'd1;
        end
      end
      // bytes after the end or after an error are not counted in byte_cnt
      PH_ENDED: begin
        r.ev = EV_AFTER_END;
        phase = PH_FAILED;
      end
      default: begin
        r.ev = EV_BAD_FORMAT;
        phase = PH_FAILED;
      end
    endcase
    r.rate = hdr_fields[15:0];
    r.chans = hdr_fields[23:16];
    r.frm_millis = hdr_fields[31:24];
    r.skip_samples = hdr_fields[47:32];
    prod = 32'(r.rate) * 32'(r.frm_millis);
    r.frame_smp = 15'(prod / MS_PER_S);
    r.end_count = trl_fields[47:16];
    r.packets = packet_cnt;
    r.bytes = byte_cnt;
  endtask

  task automatic check_field(input string fname, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches_o++;
      $display("%0t: %s expected %0h, actual %0h", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    deframe_result_t want;
    if (!rst_ni) begin
      magic_cfg = '0;
      version_cfg = 8'd1;
      codec_cfg = '0;
      trailer_cfg = '0;
      limit_cfg = 16'd1275;
      phase = PH_HEADER;
      field_idx = '0;
      magic_ok = 1'b1;
      format_ok = 1'b1;
      len_low = '0;
      rec_len = '0;
      hdr_fields = '0;
      trl_fields = '0;
      packet_cnt = '0;
      byte_cnt = '0;
      expected_events.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_MAGIC:     magic_cfg = cfg_wdata_i;
          CFG_VERSION:   version_cfg = cfg_wdata_i[7:0];
          CFG_CODEC:     codec_cfg = cfg_wdata_i[7:0];
          CFG_TRAILER:   trailer_cfg = cfg_wdata_i[15:0];
          CFG_PKT_LIMIT: limit_cfg = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with no transaction pending, expected none, actual event %0d",
                   $time, event_res_i);
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 32'(want.ev), 32'(event_res_i));
          check_field("payload_valid", 32'(want.pv), 32'(payload_valid_i));
          check_field("payload_byte", 32'(want.pb), 32'(payload_byte_i));
          check_field("payload_last", 32'(want.pl), 32'(payload_last_i));
          check_field("sample_rate", 32'(want.rate), 32'(sample_rate_i));
          check_field("channel_count", 32'(want.chans), 32'(channel_count_i));
          check_field("frame_millis", 32'(want.frm_millis), 32'(frame_millis_i));
          check_field("pre_skip_samples", 32'(want.skip_samples), 32'(pre_skip_samples_i));
          check_field("frame_samples", 32'(want.frame_smp), 32'(frame_samples_i));
          check_field("end_sample_count", want.end_count, end_sample_count_i);
          check_field("packets_seen", want.packets, packets_seen_i);
          check_field("bytes_taken", want.bytes, bytes_taken_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_stream_byte(data_byte_i, want);
        expected_events.push_back(want);
      end
    end
    pending_o = expected_events.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench import ardf_pkg::*;;

  localparam int unsigned HDR_LEN = HEADER_BYTES_DEF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_res;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [15:0] sample_rate;
  logic [7:0]  channel_count;
  logic [7:0]  frame_millis;
  logic [15:0] pre_skip_samples;
  logic [14:0] frame_samples;
  logic [31:0] end_sample_count;
  logic [31:0] packets_seen;
  logic [31:0] bytes_taken;

  int unsigned mismatches;
  int unsigned pending;

  int unsigned bytes_sent = 0;
  bit          quiet_sender = 1'b0;
  logic [15:0] trailer_code;

  audio_record_stream_deframer u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_addr_i         (cfg_addr),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .data_byte_i        (data_byte),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .event_res_o        (event_res),
    .payload_valid_o    (payload_valid),
    .payload_byte_o     (payload_byte),
    .payload_last_o     (payload_last),
    .sample_rate_o      (sample_rate),
    .channel_count_o    (channel_count),
    .frame_millis_o     (frame_millis),
    .pre_skip_samples_o (pre_skip_samples),
    .frame_samples_o    (frame_samples),
    .end_sample_count_o (end_sample_count),
    .packets_seen_o     (packets_seen),
    .bytes_taken_o      (bytes_taken)
  );

  record_stream_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_addr_i         (cfg_addr),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .data_byte_i        (data_byte),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .event_res_i        (event_res),
    .payload_valid_i    (payload_valid),
    .payload_byte_i     (payload_byte),
    .payload_last_i     (payload_last),
    .sample_rate_i      (sample_rate),
    .channel_count_i    (channel_count),
    .frame_millis_i     (frame_millis),
    .pre_skip_samples_i (pre_skip_samples),
    .frame_samples_i    (frame_samples),
    .end_sample_count_i (end_sample_count),
    .packets_seen_i     (packets_seen),
    .bytes_taken_i      (bytes_taken),
    .mismatches_o       (mismatches),
    .pending_o          (pending)
  );

  always #6 clk = ~clk;

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] corner_value(input logic [31:0] mask);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic int unsigned pick_len(input int unsigned lim);
    int unsigned cap;
    cap = ($urandom_range(0, 19) == 0) ? 200 : 12;
    if (cap > lim) cap = lim;
    return $urandom_range(1, cap);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input int unsigned len);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    repeat (len) send_byte(8'($urandom));
  endtask

  // stop offering and wait for every outstanding transaction to drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(negedge clk);
  endtask

  task automatic program_limit(input int unsigned lim);
    cfg_idx_e    other;
    logic [31:0] v;
    settle();
    write_reg(CFG_PKT_LIMIT, lim);
    other = cfg_idx_e'($urandom_range(0, 3));
    v = $urandom;
    write_reg(other, v);
    if (other == CFG_TRAILER) trailer_code = v[15:0];
    cfg_we <= 1'b0;
    quiet_sender = ($urandom_range(0, 3) == 0);
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off
  initial begin : drain
    int unsigned gap;
    int unsigned taken;
    int unsigned hold_at;
    bit          quiet;
    taken = 0;
    quiet = 1'b0;
    hold_at = $urandom_range(150, 700);
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (taken == hold_at) gap = 300;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0]  hdr [HDR_LEN];
    logic [31:0] magic;
    logic [15:0] rate;
    logic [15:0] skip_cnt;
    logic [15:0] kind;
    logic [31:0] count;
    int unsigned ending;
    int unsigned lim;
    int unsigned len;
    int unsigned p;

    wait (rst_n);
    @(negedge clk);

    // how the stream ends: bad magic, bad format, oversized length,
    // bad trailer code, or a clean trailer followed by stray bytes
    ending = $urandom_range(0, 9);

    magic = corner_value(32'hffff_ffff);
    trailer_code = 16'(corner_value(32'hffff));
    lim = ($urandom_range(0, 1) == 0) ? 1275 : $urandom_range(20, 2000);
    for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
    for (int i = 0; i < 4; i++) hdr[i] = magic[8*i +: 8];
    hdr[4] = 8'(corner_value(32'hff));
    hdr[5] = 8'(corner_value(32'hff));
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_VERSION, 32'(hdr[4]));
    write_reg(CFG_CODEC, 32'(hdr[5]));
    write_reg(CFG_TRAILER, 32'(trailer_code));
    write_reg(CFG_PKT_LIMIT, lim);
    cfg_we <= 1'b0;

    rate = 16'(corner_value(32'hffff));
    skip_cnt = 16'(corner_value(32'hffff));
    hdr[6] = rate[7:0];
    hdr[7] = rate[15:8];
    hdr[8] = 8'($urandom);
    hdr[9] = 8'(corner_value(32'hff));
    hdr[10] = skip_cnt[7:0];
    hdr[11] = skip_cnt[15:8];
    if (ending == 0) hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    // a format fault alongside a magic fault must still report bad magic
    if (ending == 1 || (ending == 0 && $urandom_range(0, 1) == 1)) begin
      p = $urandom_range(0, 5);
      hdr[(p < 2) ? 4 + p : 10 + p] ^= 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < HDR_LEN; i++) send_byte(hdr[i]);

    send_packet(1);
    send_packet(2);

    // length equal to the limit passes
    program_limit(1);
    repeat (8) send_packet(1);

    program_limit(65534);
    repeat (10) send_packet(pick_len(65534));

    lim = $urandom_range(256, 400);
    program_limit(lim);
    send_packet(lim);
    send_packet(pick_len(lim));

    while (bytes_sent < 1600) begin
      case ($urandom_range(0, 2))
        0:       lim = $urandom_range(1, 8);
        1:       lim = $urandom_range(9, 64);
        default: lim = $urandom_range(65, 65534);
      endcase
      program_limit(lim);
      repeat ($urandom_range(3, 15)) send_packet(pick_len(lim));
    end

    if (ending == 2) begin
      // a limit of zero rejects every nonzero length
      lim = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2000);
      program_limit(lim);
      case ($urandom_range(0, 2))
        0:       len = 65535;
        1:       len = lim + 1;
        default: len = $urandom_range(lim + 1, 65535);
      endcase
      send_byte(len[7:0]);
      send_byte(len[15:8]);
    end else begin
      kind = trailer_code;
      if (ending == 3) kind ^= 16'($urandom_range(1, 65535));
      count = corner_value(32'hffff_ffff);
      send_byte(8'd0);
      send_byte(8'd0);
      send_byte(kind[7:0]);
      send_byte(kind[15:8]);
      for (int i = 0; i < 4; i++) send_byte(count[8*i +: 8]);
    end
    repeat ($urandom_range(3, 20)) send_byte(8'($urandom));

    settle();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
